[rtl/pwmc_pkg.sv]
// Shared types, constants and register codes for the PWM period/duty calculator.
// No dependencies; imported by every module of the block.
package pwmc_pkg;

  localparam int unsigned FreqW   = 16;
  localparam int unsigned PresW   = 8;
  localparam int unsigned ReqW    = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  // Quotient of the period divider: 9 bits, saturation handled apart.
  localparam int unsigned QuoW    = 9;
  // Dividend is oscillator / (4 * prescale), at most 4_000_000.
  localparam int unsigned RemW    = 22;
  localparam int unsigned DivCmpW = FreqW + QuoW;
  localparam int unsigned DivStepsPerStage = 3;

  localparam logic [FreqW-1:0] FreqReset = 16'd1000;
  localparam logic [PresW-1:0] PresReset = 8'd4;

  localparam logic [RemW-1:0] DividendPre1  = 22'd4000000;
  localparam logic [RemW-1:0] DividendPre4  = 22'd1000000;
  localparam logic [RemW-1:0] DividendPre16 = 22'd250000;

  localparam logic [PresW-1:0] PresRatio1  = 8'd1;
  localparam logic [PresW-1:0] PresRatio16 = 8'd16;

  localparam logic [2:0] CtrlPre1  = 3'b100;
  localparam logic [2:0] CtrlPre4  = 3'b101;
  localparam logic [2:0] CtrlPre16 = 3'b111;

  localparam logic [7:0] PeriodMax   = 8'd255;
  localparam logic [7:0] PeriodMin   = 8'd1;
  localparam logic [6:0] PercentMax  = 7'd100;
  localparam logic [9:0] DutyLimit   = 10'd1023;

  // Divide by 100 as multiply by ceil(2^24 / 100), then shift by 24.
  localparam int unsigned PctProdW  = 17;
  localparam int unsigned RecipW    = 18;
  localparam int unsigned RecipShift = 24;
  localparam logic [RecipW-1:0] RecipHundred = 18'd167773;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFreq     = 1'b0,
    CfgPrescale = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic            operation;
    logic [ReqW-1:0] duty_request;
  } req_t;

  typedef struct packed {
    logic [7:0]  period_value;
    logic [2:0]  timer_control;
    logic [10:0] max_duty;
    logic [9:0]  applied_duty;
    logic [7:0]  duty_high;
    logic [1:0]  duty_low_bits;
  } result_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QuoW-1:0]  quo;
    logic [FreqW-1:0] freq;
  } div_t;

endpackage

[rtl/pwmc_div_stage.sv]
// One registered stage of the restoring period divider: three quotient bits.
// Depends on pwmc_pkg for the divider word layout.
module pwmc_div_stage import pwmc_pkg::*; #(
  parameter int unsigned StepHi = QuoW - 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  div_t div_i,
  output logic valid_o,
  output div_t div_o
);

  logic valid_q;
  div_t div_d, div_q;

  // Compare the partial remainder against the shifted divisor, subtract on hit.
  always_comb begin
    logic [DivCmpW-1:0] shifted;
    div_d = div_i;
    for (int k = 0; k < DivStepsPerStage; k++) begin
      shifted = DivCmpW'(div_d.freq) << (StepHi - k);
      if (DivCmpW'(div_d.rem) >= shifted) begin
        div_d.rem = div_d.rem - shifted[RemW-1:0];
        div_d.quo[StepHi - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

[rtl/pwm_period_duty_calculator.sv]
// PWM period/duty calculator top: seven-stage pipeline, uses pwmc_pkg, pwmc_div_stage.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot stall.
// The period divider (three stages of three restoring steps) sets the depth.
// Reset: frequency 1000 Hz, prescale 4, pipeline emptied; payload is not cleared.
module pwm_period_duty_calculator import pwmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                result_valid_o,
  output result_t             result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NumDivStages = QuoW / DivStepsPerStage;

  // Side payload that rides alongside the divider.
  typedef struct packed {
    logic [2:0]      ctrl;
    logic            sat;
    logic            op;
    logic [6:0]      pct;
    logic [ReqW-1:0] req;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers; they are read only in stage 1, so a write applies
  // to transactions accepted after the write edge.
  // ---------------------------------------------------------------------------
  logic [FreqW-1:0] freq_q;
  logic [PresW-1:0] pres_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FreqReset;
      pres_q <= PresReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgFreq:     freq_q <= cfg_data_i[FreqW-1:0];
        CfgPrescale: pres_q <= cfg_data_i[PresW-1:0];
        default:     ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: decode prescale, pick dividend, flag quotients of 512 and up,
  // clamp the percent request.
  // ---------------------------------------------------------------------------
  logic            s1_valid_q;
  div_t            s1_div_d, s1_div_q;
  side_t           s1_side_d, s1_side_q;

  always_comb begin
    logic [RemW-1:0] dividend;
    case (pres_q)
      PresRatio1: begin
        dividend       = DividendPre1;
        s1_side_d.ctrl = CtrlPre1;
      end
      PresRatio16: begin
        dividend       = DividendPre16;
        s1_side_d.ctrl = CtrlPre16;
      end
      default: begin
        dividend       = DividendPre4;
        s1_side_d.ctrl = CtrlPre4;
      end
    endcase
    // Zero frequency falls in here as well: any dividend >= 0.
    s1_side_d.sat = DivCmpW'(dividend) >= {freq_q, {QuoW{1'b0}}};
    s1_side_d.op  = req_i.operation;
    s1_side_d.req = req_i.duty_request;
    if (req_i.duty_request[7:0] > 8'(PercentMax)) begin
      s1_side_d.pct = PercentMax;
    end else begin
      s1_side_d.pct = req_i.duty_request[6:0];
    end
    s1_div_d.rem  = dividend;
    s1_div_d.quo  = '0;
    s1_div_d.freq = freq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_div_q  <= s1_div_d;
      s1_side_q <= s1_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2..4: restoring division, high quotient bits first.
  // ---------------------------------------------------------------------------
  logic  div_valid [NumDivStages+1];
  div_t  div_data  [NumDivStages+1];
  side_t side_q    [NumDivStages+1];

  assign div_valid[0] = s1_valid_q;
  assign div_data[0]  = s1_div_q;
  assign side_q[0]    = s1_side_q;

  for (genvar g = 0; g < NumDivStages; g++) begin : g_div
    pwmc_div_stage #(
      .StepHi(QuoW - 1 - g * DivStepsPerStage)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(div_valid[g]),
      .div_i  (div_data[g]),
      .valid_o(div_valid[g+1]),
      .div_o  (div_data[g+1])
    );

    // Carry the side payload in step with the divider.
    always_ff @(posedge clk_i) begin
      side_q[g+1] <= side_q[g];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: clamp the period, form max duty, multiply percent by max duty.
  // ---------------------------------------------------------------------------
  logic                s5_valid_q;
  logic [7:0]          s5_period_d, s5_period_q;
  logic [10:0]         s5_maxd_d, s5_maxd_q;
  logic [PctProdW-1:0] s5_prod_d, s5_prod_q;
  logic [2:0]          s5_ctrl_q;
  logic                s5_op_q;
  logic [ReqW-1:0]     s5_req_q;

  always_comb begin
    logic [QuoW-1:0] quo;
    side_t           sd;
    quo = div_data[NumDivStages].quo;
    sd  = side_q[NumDivStages];
    if (sd.sat || quo == '0) begin
      s5_period_d = PeriodMax;
    end else if (quo == QuoW'(1)) begin
      s5_period_d = PeriodMin;
    end else if (quo - QuoW'(1) > QuoW'(PeriodMax)) begin
      s5_period_d = PeriodMax;
    end else begin
      s5_period_d = 8'(quo - QuoW'(1));
    end
    s5_maxd_d = {9'(s5_period_d) + 9'd1, 2'b00};
    s5_prod_d = PctProdW'(sd.pct) * PctProdW'(s5_maxd_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= div_valid[NumDivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    s5_period_q <= s5_period_d;
    s5_maxd_q   <= s5_maxd_d;
    s5_prod_q   <= s5_prod_d;
    s5_ctrl_q   <= side_q[NumDivStages].ctrl;
    s5_op_q     <= side_q[NumDivStages].op;
    s5_req_q    <= side_q[NumDivStages].req;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: divide the percent product by 100 through the reciprocal.
  // ---------------------------------------------------------------------------
  localparam int unsigned RecipProdW = PctProdW + RecipW;

  logic                  s6_valid_q;
  logic [RecipProdW-1:0] s6_mul;
  logic [10:0]           s6_pduty_q;
  logic [7:0]            s6_period_q;
  logic [10:0]           s6_maxd_q;
  logic [2:0]            s6_ctrl_q;
  logic                  s6_op_q;
  logic [ReqW-1:0]       s6_req_q;

  assign s6_mul = RecipProdW'(s5_prod_q) * RecipProdW'(RecipHundred);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_pduty_q  <= s6_mul[RecipShift +: 11];
    s6_period_q <= s5_period_q;
    s6_maxd_q   <= s5_maxd_q;
    s6_ctrl_q   <= s5_ctrl_q;
    s6_op_q     <= s5_op_q;
    s6_req_q    <= s5_req_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: choose raw or percent duty, clamp to max duty then to 1023, split.
  // ---------------------------------------------------------------------------
  logic    out_valid_q;
  result_t out_d, out_q;

  always_comb begin
    logic [ReqW-1:0] duty;
    logic [9:0]      duty_c;
    duty = s6_op_q ? ReqW'(s6_pduty_q) : s6_req_q;
    if (duty > ReqW'(s6_maxd_q)) begin
      duty = ReqW'(s6_maxd_q);
    end
    if (duty > ReqW'(DutyLimit)) begin
      duty_c = DutyLimit;
    end else begin
      duty_c = duty[9:0];
    end
    out_d.period_value  = s6_period_q;
    out_d.timer_control = s6_ctrl_q;
    out_d.max_duty      = s6_maxd_q;
    out_d.applied_duty  = duty_c;
    out_d.duty_high     = duty_c[9:2];
    out_d.duty_low_bits = duty_c[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

`ifndef ASSERT_OFF
  localparam int unsigned Latency = 7;

  // Every accepted transaction yields a result.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 result_valid_o)
    else $error("accepted transaction produced no result");

  // No result without a matching transaction.
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept && rst_ni, Latency))
    else $error("result without accepted transaction");

  // Period stays clamped and max duty follows it.
  a_period_maxd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.period_value != 8'd0) &&
      (result_o.max_duty == {9'(result_o.period_value) + 9'd1, 2'b00}))
    else $error("period or max duty out of range");

  // Applied duty never exceeds max duty.
  a_duty_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (11'(result_o.applied_duty) <= result_o.max_duty))
    else $error("applied duty above max duty");
`endif

endmodule

[test/tb_pwm_period_duty_calculator.sv]
// Self-checking testbench for pwm_period_duty_calculator.
// Depends on pwmc_pkg (request/result structs, register indexes, constants) and on the RTL.
`timescale 1ns / 1ps

module tb_pwm_period_duty_calculator;
  import pwmc_pkg::*;

  // Oscillator rate the period divider assumes.
  localparam logic [31:0] OscHz = 32'd16000000;
  // Quiet time after the pipeline drains, before touching the registers and
  // at the end of the run.
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned MaxGap       = 13;

  // Duty request modes carried in the operation bit.
  localparam logic OpRaw     = 1'b0;
  localparam logic OpPercent = 1'b1;

  typedef enum logic {
    TxnDuty,
    TxnCfg
  } txn_kind_e;

  typedef struct {
    txn_kind_e        kind;
    req_t             req;
    logic             no_gap;
    cfg_idx_e         idx;
    logic [CfgDataW-1:0] data;
  } txn_t;

  typedef enum logic [1:0] {
    DrvFetch,
    DrvGap,
    DrvSettle,
    DrvHold
  } drv_state_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Block inputs, all known from time zero.
  logic                start     = 1'b0;
  req_t                req       = '0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic    busy;
  logic    result_valid;
  result_t result;
  logic    cfg_ready;

  // Pending stimulus and predicted results.
  txn_t    pending_txns[$];
  result_t expected_regs[$];

  // Register copy kept by the predictor.
  logic [FreqW-1:0] model_freq;
  logic [PresW-1:0] model_prescale;

  int unsigned n_errors  = 0;
  int unsigned n_duty    = 0;
  int unsigned n_percent = 0;
  int unsigned n_checked = 0;
  int unsigned n_cfg     = 0;

  drv_state_e  drv_state = DrvFetch;
  int unsigned gap_left  = 0;
  int unsigned settle_cnt = 0;

  pwm_period_duty_calculator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req),
    .result_valid_o(result_valid),
    .result_o      (result),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold reset from time zero, then release it for good.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Work out the timer registers and the clamped duty for one request,
  // using the register values in effect when the request was accepted.
  function automatic result_t calc_pwm_regs(req_t r);
    result_t     res;
    logic [31:0] ratio;
    logic [31:0] quo;
    logic [31:0] period;
    logic [31:0] maxd;
    logic [31:0] duty;
    logic [31:0] pct;
    logic [2:0]  ctrl;
    // Any ratio other than 1 or 16 runs the timer at 4.
    if (model_prescale == PresRatio1) begin
      ratio = 32'd1;
      ctrl  = CtrlPre1;
    end else if (model_prescale == PresRatio16) begin
      ratio = 32'd16;
      ctrl  = CtrlPre16;
    end else begin
      ratio = 32'd4;
      ctrl  = CtrlPre4;
    end
    // Zero frequency, or a quotient of zero, saturates the period.
    if (model_freq == '0) begin
      period = 32'(PeriodMax);
    end else begin
      quo = OscHz / (32'd4 * ratio * 32'(model_freq));
      if (quo == 32'd0) begin
        period = 32'(PeriodMax);
      end else begin
        period = quo - 32'd1;
        if (period > 32'(PeriodMax)) period = 32'(PeriodMax);
        if (period < 32'(PeriodMin)) period = 32'(PeriodMin);
      end
    end
    maxd = (period + 32'd1) * 32'd4;
    if (r.operation == OpPercent) begin
      // Only the low byte carries the percentage.
      pct = 32'(r.duty_request[7:0]);
      if (pct > 32'(PercentMax)) pct = 32'(PercentMax);
      duty = (pct * maxd) / 32'(PercentMax);
    end else begin
      duty = 32'(r.duty_request);
    end
    if (duty > maxd) duty = maxd;
    if (duty > 32'(DutyLimit)) duty = 32'(DutyLimit);
    res.period_value  = period[7:0];
    res.timer_control = ctrl;
    res.max_duty      = maxd[10:0];
    res.applied_duty  = duty[9:0];
    res.duty_high     = duty[9:2];
    res.duty_low_bits = duty[1:0];
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      n_errors++;
    end
  endtask

  // Driver: feed transactions from the pending queue. A register write waits
  // until every predicted result has come back and the pipeline has settled.
  always @(posedge clk_i) begin : driver_proc
    logic                nx_start;
    req_t                nx_req;
    logic                nx_cfg_valid;
    logic [CfgIdxW-1:0]  nx_cfg_index;
    logic [CfgDataW-1:0] nx_cfg_data;
    txn_t                cur;
    nx_start     = start;
    nx_req       = req;
    nx_cfg_valid = cfg_valid;
    nx_cfg_index = cfg_index;
    nx_cfg_data  = cfg_data;
    if (rst_ni) begin
      // Retire whatever handshake completed at this edge.
      if (start && !busy) begin
        nx_start  = 1'b0;
        drv_state = DrvFetch;
      end
      if (cfg_valid && cfg_ready) begin
        nx_cfg_valid = 1'b0;
        drv_state    = DrvFetch;
      end
      case (drv_state)
        DrvFetch: begin
          if (pending_txns.size() > 0) begin
            cur = pending_txns.pop_front();
            if (cur.kind == TxnDuty) begin
              nx_req   = cur.req;
              gap_left = cur.no_gap ? 0 : $urandom_range(0, MaxGap);
              if (gap_left == 0) begin
                nx_start  = 1'b1;
                drv_state = DrvHold;
              end else begin
                drv_state = DrvGap;
              end
            end else begin
              nx_cfg_index = cur.idx;
              nx_cfg_data  = cur.data;
              settle_cnt   = 0;
              drv_state    = DrvSettle;
            end
          end
        end
        DrvGap: begin
          gap_left--;
          if (gap_left == 0) begin
            nx_start  = 1'b1;
            drv_state = DrvHold;
          end
        end
        DrvSettle: begin
          // Write registers only once the pipeline has drained.
          if (expected_regs.size() == 0) settle_cnt++;
          else settle_cnt = 0;
          if (settle_cnt >= SettleCycles) begin
            nx_cfg_valid = 1'b1;
            drv_state    = DrvHold;
          end
        end
        default: ;
      endcase
    end
    start     <= nx_start;
    req       <= nx_req;
    cfg_valid <= nx_cfg_valid;
    cfg_index <= nx_cfg_index;
    cfg_data  <= nx_cfg_data;
  end

  // Monitor: predict at each accepted request, track register writes, and
  // compare every strobed result with the oldest prediction.
  always @(posedge clk_i) begin : monitor_proc
    result_t exp_res;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_regs.push_back(calc_pwm_regs(req));
        n_duty++;
        if (req.operation == OpPercent) n_percent++;
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        if (cfg_index == CfgFreq) model_freq = cfg_data;
        else model_prescale = cfg_data[PresW-1:0];
      end
      if (result_valid) begin
        if (expected_regs.size() == 0) begin
          $error("result strobed with no request outstanding");
          n_errors++;
        end else begin
          exp_res = expected_regs.pop_front();
          n_checked++;
          check_field("period_value", 32'(exp_res.period_value),
                      32'(result.period_value));
          check_field("timer_control", 32'(exp_res.timer_control),
                      32'(result.timer_control));
          check_field("max_duty", 32'(exp_res.max_duty), 32'(result.max_duty));
          check_field("applied_duty", 32'(exp_res.applied_duty),
                      32'(result.applied_duty));
          check_field("duty_high", 32'(exp_res.duty_high), 32'(result.duty_high));
          check_field("duty_low_bits", 32'(exp_res.duty_low_bits),
                      32'(result.duty_low_bits));
        end
      end
    end
  end

  task automatic add_duty(logic op, logic [ReqW-1:0] value, logic no_gap);
    txn_t t;
    t.kind             = TxnDuty;
    t.req.operation    = op;
    t.req.duty_request = value;
    t.no_gap           = no_gap;
    t.idx              = CfgFreq;
    t.data             = '0;
    pending_txns.push_back(t);
  endtask

  task automatic add_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    txn_t t;
    t.kind   = TxnCfg;
    t.req    = '0;
    t.no_gap = 1'b0;
    t.idx    = idx;
    t.data   = value;
    pending_txns.push_back(t);
  endtask

  // Random frequency: half over the whole field, half in the band that
  // spreads the period across its range.
  function automatic logic [CfgDataW-1:0] rand_freq();
    if ($urandom_range(0, 1) == 0) return CfgDataW'($urandom_range(0, 65535));
    return CfgDataW'($urandom_range(1, 5000));
  endfunction

  // Random prescale: mostly the three real ratios, otherwise any byte;
  // junk in the upper data byte must be dropped by the block.
  function automatic logic [CfgDataW-1:0] rand_prescale();
    logic [7:0] pres;
    case ($urandom_range(0, 4))
      0:       pres = PresRatio1;
      1:       pres = 8'd4;
      2:       pres = PresRatio16;
      default: pres = 8'($urandom_range(0, 255));
    endcase
    return {8'($urandom_range(0, 255)), pres};
  endfunction

  task automatic add_random_duty(logic no_gap);
    logic [ReqW-1:0] value;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 2) == 0) value = ReqW'($urandom_range(0, 65535));
      else value = ReqW'($urandom_range(0, 1100));
      add_duty(OpRaw, value, no_gap);
    end else begin
      value[15:8] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) value[7:0] = 8'($urandom_range(0, 100));
      else value[7:0] = 8'($urandom_range(0, 255));
      add_duty(OpPercent, value, no_gap);
    end
  endtask

  initial begin : stimulus_proc
    int unsigned phase_len;
    logic        burst;
    logic        wrote;
    model_freq     = FreqReset;
    model_prescale = PresReset;

    // Reset settings: period saturates, max duty 1024, duty limit applies.
    add_duty(OpRaw, 16'd0, 1'b0);
    add_duty(OpRaw, 16'hFFFF, 1'b1);
    add_duty(OpRaw, 16'd1023, 1'b1);
    add_duty(OpRaw, 16'd1024, 1'b0);
    add_duty(OpPercent, 16'd100, 1'b0);
    add_duty(OpPercent, 16'd101, 1'b1);
    add_duty(OpPercent, 16'hFF00, 1'b0);
    add_duty(OpPercent, 16'hA532, 1'b0);
    // Highest frequency with ratio 16: tiny period, raw clamp to max duty.
    add_cfg(CfgFreq, 16'hFFFF);
    add_cfg(CfgPrescale, 16'hFF10);
    add_duty(OpRaw, 16'd12, 1'b0);
    add_duty(OpRaw, 16'd13, 1'b1);
    add_duty(OpPercent, 16'd99, 1'b0);
    add_duty(OpPercent, 16'd255, 1'b0);
    // Zero frequency with ratio 1: saturated period, full percent.
    add_cfg(CfgFreq, 16'd0);
    add_cfg(CfgPrescale, 16'h0001);
    add_duty(OpPercent, 16'd100, 1'b0);
    add_duty(OpRaw, 16'd1023, 1'b0);
    // Ratio 0 falls back to 4.
    add_cfg(CfgPrescale, 16'h0000);
    add_duty(OpRaw, 16'd500, 1'b0);
    add_duty(OpPercent, 16'd37, 1'b0);
    // Lowest nonzero frequency with ratio 255.
    add_cfg(CfgFreq, 16'd1);
    add_cfg(CfgPrescale, 16'h00FF);
    add_duty(OpPercent, 16'd1, 1'b0);
    add_duty(OpRaw, 16'd1, 1'b0);
    // Mid-range period with an exact percent and a raw clamp to max duty.
    add_cfg(CfgFreq, 16'd20000);
    add_cfg(CfgPrescale, 16'h0004);
    add_duty(OpPercent, 16'd3, 1'b0);
    add_duty(OpRaw, 16'd201, 1'b0);

    // Random phases: new settings, then a run of requests, some back to back.
    for (int p = 0; p < 10; p++) begin
      wrote = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        add_cfg(CfgFreq, rand_freq());
        wrote = 1'b1;
      end
      if (!wrote || $urandom_range(0, 3) != 0) add_cfg(CfgPrescale, rand_prescale());
      burst     = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(43, 63);
      for (int i = 0; i < phase_len; i++) add_random_duty(burst);
    end

    // Drain: everything sent, every prediction matched, pipeline quiet.
    while (pending_txns.size() != 0 || drv_state != DrvFetch || start || cfg_valid ||
           expected_regs.size() != 0)
      @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d duty requests (%0d in percent mode) across %0d register writes.",
             n_duty, n_percent, n_cfg);
    $display("Compared %0d results field by field, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("pwm_period_duty_calculator test passed");
    end else begin
      $display("pwm_period_duty_calculator test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout: %0d requests sent, %0d results outstanding.", n_duty,
             expected_regs.size());
    $display("pwm_period_duty_calculator test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/pwmc_pkg.sv
rtl/pwmc_div_stage.sv
rtl/pwm_period_duty_calculator.sv
test/tb_pwm_period_duty_calculator.sv
